@@ sv/coalesced_chain_hash_table_assert.svh @@
// Assertion macros for the coalesced chain hash table.
// Included by the top level; compiled out when SYNTHESIS is set.
`ifndef COALESCED_CHAIN_HASH_TABLE_ASSERT_SVH
`define COALESCED_CHAIN_HASH_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define CHT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CHT_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define CHT_ASSERT(name, prop, msg)
`define CHT_ASSERT_RST(name, prop, msg)
`endif

`endif

@@ sv/cht_pkg.sv @@
// Shared types and codes for the coalesced chain hash table.
// Used by cht_ctrl, cht_dp and the top level; no dependencies.
`timescale 1ns / 1ps

package cht_pkg;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH_MUL,
        S_HASH_QD,
        S_HASH_FIN,
        S_DISPATCH,
        S_SCAN,
        S_WALK_RD,
        S_WALK_CHK,
        S_EMIT
    } cht_state_t;

    typedef struct packed {
        logic load_in;
        logic hash_mul;
        logic hash_qd;
        logic hash_fin;
        logic write_home;
        logic scan_next;
        logic walk_adv;
        logic link;
        logic res_found;
        logic res_full;
        logic res_not_found;
        logic emit;
    } cht_cmd_t;

    typedef struct packed {
        logic func_search;
        logic home_valid;
        logic scan_free;
        logic scan_last;
        logic match;
        logic walk_stop;
        logic out_free;
    } cht_stat_t;

endpackage

@@ sv/cht_ctrl.sv @@
// Controller state machine for the coalesced chain hash table.
// Depends on cht_pkg; drives cht_dp through cht_cmd_t.
`timescale 1ns / 1ps

module cht_ctrl import cht_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  cht_stat_t stat,
    output cht_cmd_t  cmd
);

    cht_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_HASH_MUL;
                end
            end
            S_HASH_MUL: begin
                cmd.hash_mul = 1'b1;
                state_next   = S_HASH_QD;
            end
            S_HASH_QD: begin
                cmd.hash_qd = 1'b1;
                state_next  = S_HASH_FIN;
            end
            S_HASH_FIN: begin
                cmd.hash_fin = 1'b1;
                state_next   = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (stat.func_search) begin
                    state_next = S_WALK_RD;
                end else if (!stat.home_valid) begin
                    cmd.write_home = 1'b1;
                    state_next     = S_EMIT;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.scan_free) begin
                    state_next = S_WALK_RD;
                end else if (stat.scan_last) begin
                    cmd.res_full = 1'b1;
                    state_next   = S_EMIT;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_WALK_RD: begin
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (stat.func_search) begin
                    if (stat.match) begin
                        cmd.res_found = 1'b1;
                        state_next    = S_EMIT;
                    end else if (stat.walk_stop) begin
                        cmd.res_not_found = 1'b1;
                        state_next        = S_EMIT;
                    end else begin
                        cmd.walk_adv = 1'b1;
                    end
                end else if (stat.walk_stop) begin
                    cmd.link   = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    cmd.walk_adv = 1'b1;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/cht_dp.sv @@
// Datapath for the coalesced chain hash table: hash unit, slot stores,
// free-slot scan, chain walk and output register. Depends on cht_pkg.
`timescale 1ns / 1ps

module cht_dp import cht_pkg::*; #(
    parameter int SLOTS    = 10,
    parameter int KEY_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  cht_cmd_t    cmd,
    output cht_stat_t   stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata
);

    localparam int KW = (KEY_BITS < 16) ? KEY_BITS : 16;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SH = KW + 7;
    localparam int PW = KW + SH;
    localparam int DW = KW + 7;
    localparam longint unsigned RECIP_L = (64'd1 << SH) / SLOTS;
    localparam logic [SH-1:0] RECIP      = SH'(RECIP_L);
    localparam logic [7:0]    SLOTS_8    = 8'(SLOTS);
    localparam logic [7:0]    SLOTS_M1_8 = 8'(SLOTS - 1);
    localparam logic [SW-1:0] LAST_IDX   = SW'(SLOTS - 1);
    localparam logic [SW:0]   SLOTS_X    = (SW + 1)'(SLOTS);
    localparam logic [CW-1:0] CNT_SEARCH = CW'(SLOTS - 1);
    localparam logic [CW-1:0] CNT_INSERT = CW'(SLOTS);

    logic              func_reg;
    logic [KW-1:0]     key_reg;
    logic [PW-1:0]     prod_reg;
    logic [DW-1:0]     qd_reg;
    logic [SW-1:0]     home_reg;
    logic [SW-1:0]     cur_reg;
    logic [SW-1:0]     scan_reg;
    logic [CW-1:0]     cnt_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  hnext_reg;
    logic [KW-1:0]     key_q;
    logic [SW-1:0]     nxt_q;
    logic [1:0]        res_status_reg;
    logic [3:0]        res_slot_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;

    logic [KW-1:0]     key_mem [SLOTS];
    logic [SW-1:0]     nxt_mem [SLOTS];

    logic [KW-1:0]     quot;
    logic [DW-1:0]     diff;
    logic [7:0]        rem_raw;
    logic [7:0]        rem_fix;
    logic [SW-1:0]     home_calc;
    logic [SW-1:0]     rd_addr;
    logic [SW-1:0]     wr_addr;
    logic [CW-1:0]     cnt_lim;

    // key mod SLOTS by reciprocal multiply; estimate is low by at most one
    assign quot      = prod_reg[PW-1:SH];
    assign diff      = DW'(key_reg) - qd_reg;
    assign rem_raw   = diff[7:0];
    assign rem_fix   = (rem_raw >= SLOTS_8) ? (rem_raw - SLOTS_8) : rem_raw;
    assign home_calc = (rem_fix == SLOTS_M1_8) ? '0 : SW'(rem_fix + 8'd1);

    assign rd_addr = cmd.walk_adv ? nxt_q : cur_reg;
    assign wr_addr = cmd.link ? scan_reg : home_reg;
    assign cnt_lim = func_reg ? CNT_SEARCH : CNT_INSERT;

    always_comb begin
        stat.func_search = func_reg;
        stat.home_valid  = valid_reg[home_reg];
        stat.scan_free   = !valid_reg[scan_reg];
        stat.scan_last   = (scan_reg == LAST_IDX);
        stat.match       = valid_reg[cur_reg] && (key_q == key_reg);
        stat.walk_stop   = !hnext_reg[cur_reg] || ({1'b0, nxt_q} >= SLOTS_X)
                           || (cnt_reg == cnt_lim);
        stat.out_free    = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg <= s_tuser;
            key_reg  <= s_tdata[KW-1:0];
        end
        if (cmd.hash_mul) begin
            prod_reg <= PW'(key_reg) * PW'(RECIP);
        end
        if (cmd.hash_qd) begin
            qd_reg <= DW'(quot) * DW'(SLOTS);
        end
        if (cmd.hash_fin) begin
            home_reg <= home_calc;
            cur_reg  <= home_calc;
            scan_reg <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.scan_next) begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.walk_adv) begin
            cur_reg <= nxt_q;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.write_home) begin
            res_status_reg <= ST_INSERTED;
            res_slot_reg   <= 4'(home_reg);
        end else if (cmd.link) begin
            res_status_reg <= ST_INSERTED;
            res_slot_reg   <= 4'(scan_reg);
        end else if (cmd.res_found) begin
            res_status_reg <= ST_FOUND;
            res_slot_reg   <= 4'(cur_reg);
        end else if (cmd.res_full) begin
            res_status_reg <= ST_FULL;
            res_slot_reg   <= '0;
        end else if (cmd.res_not_found) begin
            res_status_reg <= ST_NOT_FOUND;
            res_slot_reg   <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_home || cmd.link) begin
            key_mem[wr_addr] <= key_reg;
        end
        key_q <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.link) begin
            nxt_mem[cur_reg] <= scan_reg;
        end
        nxt_q <= nxt_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hnext_reg <= '0;
        end else begin
            if (cmd.write_home || cmd.link) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.link) begin
                hnext_reg[cur_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {2'b00, res_slot_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ sv/coalesced_chain_hash_table.sv @@
// After accept: hash multiply, quotient, finish, dispatch. An insert to an empty home
// slot writes it; a search walks the chain from home; other inserts scan for a free
// slot and walk to the chain tail (free-slot scan and chain walk, one slot a cycle).
// One word in flight: the next is accepted the cycle after the result is loaded into the
// output register, even while that result still waits to drain.
// Synchronous active-low reset clears valid marks, links and handshake state.
`timescale 1ns / 1ps

`include "coalesced_chain_hash_table_assert.svh"

module coalesced_chain_hash_table import cht_pkg::*; #(
    parameter int SLOTS    = 10,
    parameter int KEY_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] key
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] status, [5:2] slot, [7:6] zero
);

    cht_cmd_t  cmd;
    cht_stat_t stat;

    cht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cht_dp #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `CHT_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "accepted while busy")
    `CHT_ASSERT(a_emit_when_free, cmd.emit |-> stat.out_free, "result overwrote pending word")
    `CHT_ASSERT(a_zero_slot, (m_tvalid && (m_tdata[1:0] == ST_FULL || m_tdata[1:0] == ST_NOT_FOUND)) |-> (m_tdata[5:2] == 4'd0), "nonzero slot on miss")
    `CHT_ASSERT_RST(a_reset_idle, !aresetn |=> (!m_tvalid && s_tready), "not idle after reset")

endmodule

@@ sim/tb_coalesced_chain_hash_table.sv @@
// Self-checking testbench for coalesced_chain_hash_table: insert/search words over the
// stream ports, checked against an in-bench copy of the table and its chain links.
// Depends on cht_pkg and the top level only.
`timescale 1ns / 1ps

module tb_coalesced_chain_hash_table;
    import cht_pkg::*;

    localparam int SLOTS     = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] key;
    } op_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    op_word_t    ops_to_send[$];
    reply_t      replies_due[$];
    logic [15:0] loaded_keys[$];

    // shadow table
    logic [15:0] tbl_key[SLOTS];
    logic        tbl_used[SLOTS];
    int          tbl_link[SLOTS];
    logic        tbl_linked[SLOTS];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int fail_count = 0;

    always #5 aclk = ~aclk;

    coalesced_chain_hash_table #(
        .SLOTS   (SLOTS),
        .KEY_BITS(16)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    function automatic reply_t table_op(input op_t op, input logic [15:0] key);
        int     home;
        int     cur;
        int     free_idx;
        int     n;
        reply_t r;
        home = ((int'(key) % SLOTS) + 1) % SLOTS;
        r.status = ST_NOT_FOUND;
        r.slot = '0;
        if (op == OP_INSERT) begin
            if (!tbl_used[home]) begin
                tbl_key[home] = key;
                tbl_used[home] = 1'b1;
                r.status = ST_INSERTED;
                r.slot = 4'(home);
            end else begin
                free_idx = -1;
                for (n = 0; n < SLOTS; n++)
                    if (!tbl_used[n] && free_idx < 0)
                        free_idx = n;
                if (free_idx < 0) begin
                    r.status = ST_FULL;
                end else begin
                    cur = home;
                    for (n = 0; n < SLOTS && tbl_linked[cur]; n++)
                        cur = tbl_link[cur];
                    tbl_key[free_idx] = key;
                    tbl_used[free_idx] = 1'b1;
                    tbl_link[cur] = free_idx;
                    tbl_linked[cur] = 1'b1;
                    r.status = ST_INSERTED;
                    r.slot = 4'(free_idx);
                end
            end
        end else begin
            cur = home;
            for (n = 0; n < SLOTS; n++) begin
                if (tbl_used[cur] && tbl_key[cur] == key) begin
                    r.status = ST_FOUND;
                    r.slot = 4'(cur);
                    return r;
                end
                if (!tbl_linked[cur])
                    break;
                cur = tbl_link[cur];
            end
        end
        return r;
    endfunction

    task automatic flag(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic push_op(input op_t op, input logic [15:0] key);
        op_word_t w;
        w.op = op;
        w.key = key;
        ops_to_send.push_back(w);
        if (op == OP_INSERT)
            loaded_keys.push_back(key);
    endtask

    // driver
    always @(posedge aclk) begin
        op_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                replies_due.push_back(table_op(op_t'(s_tuser), s_tdata));
            if (ops_to_send.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                w = ops_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= w.key;
                s_tuser  <= w.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    int replies_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                replies_seen++;
                if (replies_due.size() == 0) begin
                    flag($sformatf("unexpected word: status %0d slot %0d",
                                   m_tdata[1:0], m_tdata[5:2]));
                end else begin
                    want = replies_due.pop_front();
                    if (m_tdata[1:0] != want.status || m_tdata[5:2] != want.slot
                            || m_tdata[7:6] != 2'b00)
                        flag($sformatf("mismatch: expected status %0d slot %0d, got status %0d slot %0d pad %0d",
                                       want.status, want.slot, m_tdata[1:0], m_tdata[5:2],
                                       m_tdata[7:6]));
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // one long receiver hold-off, counted in cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && replies_seen >= 300) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // watchdog
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int idle_pcts[4];
        int stall_pcts[4];
        int r;
        int p;
        int k;
        idle_pcts = '{0, 51, 0, 20};
        stall_pcts = '{0, 0, 51, 20};
        for (k = 0; k < SLOTS; k++) begin
            tbl_used[k] = 1'b0;
            tbl_linked[k] = 1'b0;
            tbl_key[k] = '0;
            tbl_link[k] = 0;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // empty home, collisions, coalesced chains, duplicates, fill and full
        push_op(OP_SEARCH, 16'd0);
        push_op(OP_INSERT, 16'd0);
        push_op(OP_INSERT, 16'd10);
        push_op(OP_INSERT, 16'd9);
        push_op(OP_INSERT, 16'd20);
        push_op(OP_INSERT, 16'hFFFF);
        push_op(OP_INSERT, 16'hFFFF);
        push_op(OP_SEARCH, 16'hFFFF);
        push_op(OP_SEARCH, 16'd20);
        push_op(OP_SEARCH, 16'd30);
        push_op(OP_INSERT, 16'd65525);
        push_op(OP_INSERT, 16'h8000);
        push_op(OP_INSERT, 16'd7);
        push_op(OP_INSERT, 16'd6);
        push_op(OP_INSERT, 16'd1234);
        push_op(OP_SEARCH, 16'd7);
        push_op(OP_SEARCH, 16'd1234);
        push_op(OP_SEARCH, 16'd9);
        push_op(OP_SEARCH, 16'd10);
        push_op(OP_SEARCH, 16'd0);
        push_op(OP_SEARCH, 16'd65525);
        push_op(OP_SEARCH, 16'h8000);
        push_op(OP_INSERT, 16'd0);
        push_op(OP_SEARCH, 16'hAAAA);
        push_op(OP_SEARCH, 16'h5555);

        for (p = 0; p < 4; p++) begin
            while (ops_to_send.size() != 0) @(posedge aclk);
            src_idle_pct <= idle_pcts[p];
            snk_stall_pct <= stall_pcts[p];
            for (k = 0; k < 500; k++) begin
                r = $urandom_range(99);
                if (r < 25)
                    push_op(OP_INSERT, 16'($urandom_range(65535)));
                else if (r < 65)
                    push_op(OP_SEARCH, loaded_keys[$urandom_range(loaded_keys.size() - 1)]);
                else if (r < 80)
                    push_op(OP_SEARCH, 16'(loaded_keys[$urandom_range(loaded_keys.size() - 1)]
                                           + 10 * $urandom_range(1, 50)));
                else
                    push_op(OP_SEARCH, 16'($urandom_range(65535)));
            end
        end

        // sample between edges so the driver's updates have settled
        while (ops_to_send.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(negedge aclk);
        repeat (40) @(posedge aclk);

        if (fail_count == 0 && replies_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ coalesced_chain_hash_table.f @@
+incdir+sv
sv/cht_pkg.sv
sv/cht_ctrl.sv
sv/cht_dp.sv
sv/coalesced_chain_hash_table.sv
sim/tb_coalesced_chain_hash_table.sv
